// File: hdl/wvcf_pkg.sv
// ----------------------------------------------------------------------------
// Windowed variance package
// Shared payload types, configuration types, register indexes and the
// engine state encoding for the windowed variance block.
// ----------------------------------------------------------------------------
package wvcf_pkg;

    // Saturation limit of a Q22.12 covariance value.
    localparam logic [33:0] COV_MAX = 34'h3_FFFF_FFFF;

    // Fraction bits of the Q12.12 format.
    localparam int Q_SHIFT = 12;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FILTER_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_REJECT_THRESH  = 3'd1;
    localparam logic [2:0] CFG_WINDOW_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_COMPARE_IN     = 3'd3;
    localparam logic [2:0] CFG_FLOOR_LEVEL    = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  WINDOW_LIMIT_RST = 8'd100;
    localparam logic [33:0] FLOOR_LEVEL_RST  = 34'd4;

    // One input item.
    typedef struct packed {
        logic [3:0]         channel;
        logic signed [23:0] sample;
        logic [33:0]        incoming_cov;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [3:0]  out_channel;
        logic [33:0] covariance_out;
        logic        sample_kept;
        logic [7:0]  window_count;
    } out_item_t;

    // Configuration register contents.
    typedef struct packed {
        logic        filter_enable;
        logic [23:0] reject_threshold;
        logic [7:0]  window_limit;
        logic        compare_with_incoming;
        logic [33:0] floor_level;
    } cfg_t;

    // Queue head handed from the front end to the engine.
    typedef struct packed {
        logic     valid;
        logic     chan_ok;
        in_item_t data;
    } fr_to_bk_t;

    // Engine status returned to the front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_to_fr_t;

    // Engine sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_NEW,
        ST_CMP,
        ST_OLD,
        ST_SQ,
        ST_UPD,
        ST_MUL,
        ST_DIFF,
        ST_DIV,
        ST_DONE
    } bk_state_t;

endpackage

// File: hdl/wvcf_front.sv
// ----------------------------------------------------------------------------
// Windowed variance front end
// Accepts input transfers, checks the channel index and holds items in a
// two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
module wvcf_front #(
    parameter int CHANNELS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wvcf_pkg::in_item_t  s_data,
    output wvcf_pkg::fr_to_bk_t head,
    input  wvcf_pkg::bk_to_fr_t status
);

    // Queue storage: channel check result plus payload.
    typedef struct packed {
        logic               chan_ok;
        wvcf_pkg::in_item_t data;
    } entry_t;

    entry_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    // Items are held off while the window memory is being cleared.
    assign s_ready = (count_reg != 2'd2) && !status.clearing;
    assign push    = s_valid && s_ready;
    assign pop     = status.pop && (count_reg != 2'd0);

    assign head.valid   = (count_reg != 2'd0);
    assign head.chan_ok = entry_reg[rd_ptr_reg].chan_ok;
    assign head.data    = entry_reg[rd_ptr_reg].data;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify the channel on the way in.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg].chan_ok <= ({1'b0, s_data.channel} < 5'(CHANNELS));
            entry_reg[wr_ptr_reg].data    <= s_data;
        end
    end

endmodule

// File: hdl/wvcf_back.sv
// ----------------------------------------------------------------------------
// Windowed variance engine
// Keeps the per-channel sample windows and running sums, updates them for
// one item at a time and computes the sample variance with a bit-serial
// divider, then presents the result in an output register.
// ----------------------------------------------------------------------------
module wvcf_back #(
    parameter int WINDOW_DEPTH = 128,
    parameter int CHANNELS     = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wvcf_pkg::cfg_t      cfg,
    input  wvcf_pkg::fr_to_bk_t head,
    output wvcf_pkg::bk_to_fr_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output wvcf_pkg::out_item_t m_data
);

    localparam int LD    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = FW + 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEMD  = CHANNELS * WINDOW_DEPTH;
    localparam int AW    = (MEMD > 1) ? $clog2(MEMD) : 1;
    localparam int SUMW  = 24 + FW;
    localparam int SQW   = 46 + FW;
    localparam int PW    = SQW + FW;
    localparam int QW    = PW - wvcf_pkg::Q_SHIFT;
    localparam int MW    = 2 * FW;
    localparam int CNTW  = $clog2(QW + 1);

    wvcf_pkg::bk_state_t state_reg, state_next;

    // Window memory and clearing pass.
    logic signed [23:0] mem [MEMD];
    logic signed [23:0] rdata_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [23:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [AW-1:0]      clr_reg;

    // Per-channel window state.
    logic [LD-1:0]          head_arr_reg [CHANNELS];
    logic [FW-1:0]          fill_arr_reg [CHANNELS];
    logic signed [SUMW-1:0] sum_arr_reg  [CHANNELS];
    logic [SQW-1:0]         sq_arr_reg   [CHANNELS];

    // Working registers for the item in flight.
    logic [3:0]             chan_reg;
    logic                   ok_reg;
    logic [CW-1:0]          ch_reg;
    logic signed [23:0]     x_reg;
    logic [33:0]            inc_reg;
    logic [LD-1:0]          head_reg;
    logic [FW-1:0]          fill_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [SQW-1:0]         sq_reg;
    logic [FW-1:0]          limit_reg;
    logic                   keep_reg;
    logic signed [23:0]     old_reg;
    logic [47:0]            sqo_reg;
    logic [47:0]            sqx_reg;
    logic [PW-1:0]          nq_reg;
    logic [PW-1:0]          ss_reg;
    logic [MW-1:0]          m_reg;
    logic [QW-1:0]          num_reg;
    logic [MW-1:0]          rem_reg;
    logic [CNTW-1:0]        cnt_reg;

    // Output register.
    logic                  m_valid_reg;
    wvcf_pkg::out_item_t   m_data_reg;
    logic                  out_load;

    // Combinational helpers.
    logic               pop_req;
    logic [CW-1:0]      pop_ch;
    logic [15:0]        wl16;
    logic [FW-1:0]      limit_w;
    logic [AW-1:0]      base_w;
    logic [SW-1:0]      newest_sum;
    logic [LD-1:0]      newest_slot;
    logic [SW-1:0]      wr_sum;
    logic [LD-1:0]      wr_slot;
    logic [LD-1:0]      head_inc;
    logic signed [24:0] dif;
    logic [24:0]        dif_mag;
    logic [23:0]        x_mag;
    logic [23:0]        old_mag;
    logic [47:0]        sqx_full;
    logic [47:0]        sqo_full;
    logic               evict;
    logic signed [SUMW-1:0] sum_upd;
    logic [SQW-1:0]     sq_upd;
    logic [SUMW-1:0]    sum_mag;
    logic [2*SUMW-1:0]  ss_full;
    logic [PW-1:0]      nq_full;
    logic [MW-1:0]      m_full;
    logic [PW-1:0]      diff_w;
    logic [MW:0]        trial;
    logic               trial_ge;
    logic [33:0]        var_w;
    logic [33:0]        cov_w;

    assign status.clearing = (state_reg == wvcf_pkg::ST_CLEAR);
    assign status.pop      = pop_req;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Effective window limit: zero acts as one, above the depth acts as the depth.
    assign wl16    = {8'd0, cfg.window_limit};
    assign limit_w = (wl16 == 16'd0) ? FW'(1) :
                     (wl16 > 16'(WINDOW_DEPTH)) ? FW'(WINDOW_DEPTH) : FW'(wl16);
    assign pop_ch  = head.data.channel[CW-1:0];

    // Slot arithmetic within the circular window.
    assign base_w      = AW'(ch_reg) * AW'(WINDOW_DEPTH);
    assign newest_sum  = SW'(head_reg) + SW'(fill_reg) - SW'(1);
    assign newest_slot = (newest_sum >= SW'(WINDOW_DEPTH)) ?
                         LD'(newest_sum - SW'(WINDOW_DEPTH)) : LD'(newest_sum);
    assign wr_sum      = SW'(head_reg) + SW'(fill_reg);
    assign wr_slot     = (wr_sum >= SW'(WINDOW_DEPTH)) ?
                         LD'(wr_sum - SW'(WINDOW_DEPTH)) : LD'(wr_sum);
    assign head_inc    = (head_reg == LD'(WINDOW_DEPTH - 1)) ? '0 : head_reg + LD'(1);

    // Rejection distance to the newest kept sample.
    assign dif     = {x_reg[23], x_reg} - {rdata_reg[23], rdata_reg};
    assign dif_mag = dif[24] ? 25'(-dif) : 25'(dif);

    // Squares of the new and the evicted sample.
    assign x_mag    = x_reg[23] ? 24'(-x_reg) : 24'(x_reg);
    assign old_mag  = old_reg[23] ? 24'(-old_reg) : 24'(old_reg);
    assign sqx_full = x_mag * x_mag;
    assign sqo_full = old_mag * old_mag;

    // Running sum updates; the write slot is the same with or without eviction.
    assign evict   = (fill_reg >= limit_reg);
    assign sum_upd = sum_reg + SUMW'(x_reg) - (evict ? SUMW'(old_reg) : '0);
    assign sq_upd  = sq_reg + SQW'(sqx_reg) - (evict ? SQW'(sqo_reg) : '0);

    // Variance numerator terms and divisor.
    assign sum_mag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign ss_full = sum_mag * sum_mag;
    assign nq_full = fill_reg * sq_reg;
    assign m_full  = fill_reg * (fill_reg - FW'(1));
    assign diff_w  = nq_reg - ss_reg;

    // One restoring division step.
    assign trial    = {rem_reg, num_reg[QW-1]};
    assign trial_ge = (trial >= {1'b0, m_reg});

    // Final covariance: saturate, then take the max with the selected floor.
    assign var_w = (num_reg > QW'(wvcf_pkg::COV_MAX)) ? wvcf_pkg::COV_MAX : num_reg[33:0];
    always_comb begin
        if (cfg.compare_with_incoming) begin
            cov_w = (inc_reg > var_w) ? inc_reg : var_w;
        end else begin
            cov_w = (cfg.floor_level > var_w) ? cfg.floor_level : var_w;
        end
    end

    assign out_load = (state_reg == wvcf_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    // Sequencer: next state, memory port control and queue pop.
    always_comb begin
        state_next = state_reg;
        pop_req    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = base_w + AW'(wr_slot);
        mem_wdata  = x_reg;
        mem_raddr  = base_w + AW'(newest_slot);
        unique case (state_reg)
            wvcf_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(MEMD - 1)) begin
                    state_next = wvcf_pkg::ST_IDLE;
                end
            end
            wvcf_pkg::ST_IDLE: begin
                if (head.valid) begin
                    pop_req    = 1'b1;
                    state_next = head.chan_ok ? wvcf_pkg::ST_RD_NEW : wvcf_pkg::ST_DONE;
                end
            end
            wvcf_pkg::ST_RD_NEW: begin
                state_next = wvcf_pkg::ST_CMP;
            end
            wvcf_pkg::ST_CMP: begin
                mem_raddr  = base_w + AW'(head_reg);
                state_next = wvcf_pkg::ST_OLD;
            end
            wvcf_pkg::ST_OLD: begin
                state_next = wvcf_pkg::ST_SQ;
            end
            wvcf_pkg::ST_SQ: begin
                state_next = wvcf_pkg::ST_UPD;
            end
            wvcf_pkg::ST_UPD: begin
                mem_we     = keep_reg;
                state_next = wvcf_pkg::ST_MUL;
            end
            wvcf_pkg::ST_MUL: begin
                state_next = wvcf_pkg::ST_DIFF;
            end
            wvcf_pkg::ST_DIFF: begin
                if ((fill_reg < FW'(2)) || (nq_reg <= ss_reg)) begin
                    state_next = wvcf_pkg::ST_DONE;
                end else begin
                    state_next = wvcf_pkg::ST_DIV;
                end
            end
            wvcf_pkg::ST_DIV: begin
                if (cnt_reg == CNTW'(1)) begin
                    state_next = wvcf_pkg::ST_DONE;
                end
            end
            wvcf_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = wvcf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wvcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wvcf_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == wvcf_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    // Window memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Per-channel state: seeded with one zero sample at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                head_arr_reg[c] <= '0;
                fill_arr_reg[c] <= FW'(1);
                sum_arr_reg[c]  <= '0;
                sq_arr_reg[c]   <= '0;
            end
        end else if ((state_reg == wvcf_pkg::ST_UPD) && keep_reg) begin
            head_arr_reg[ch_reg] <= evict ? head_inc : head_reg;
            fill_arr_reg[ch_reg] <= evict ? fill_reg : fill_reg + FW'(1);
            sum_arr_reg[ch_reg]  <= sum_upd;
            sq_arr_reg[ch_reg]   <= sq_upd;
        end
    end

    // Datapath of the item in flight.
    always_ff @(posedge aclk) begin
        case (state_reg)
            wvcf_pkg::ST_IDLE: begin
                chan_reg  <= head.data.channel;
                ok_reg    <= head.chan_ok;
                ch_reg    <= pop_ch;
                x_reg     <= head.data.sample;
                inc_reg   <= head.data.incoming_cov;
                limit_reg <= limit_w;
                num_reg   <= '0;
                keep_reg  <= 1'b0;
                if (head.chan_ok) begin
                    head_reg <= head_arr_reg[pop_ch];
                    fill_reg <= fill_arr_reg[pop_ch];
                    sum_reg  <= sum_arr_reg[pop_ch];
                    sq_reg   <= sq_arr_reg[pop_ch];
                end
            end
            wvcf_pkg::ST_CMP: begin
                keep_reg <= !(cfg.filter_enable && (dif_mag <= {1'b0, cfg.reject_threshold}));
            end
            wvcf_pkg::ST_OLD: begin
                old_reg <= rdata_reg;
            end
            wvcf_pkg::ST_SQ: begin
                sqx_reg <= sqx_full;
                sqo_reg <= sqo_full;
            end
            wvcf_pkg::ST_UPD: begin
                if (keep_reg) begin
                    head_reg <= evict ? head_inc : head_reg;
                    fill_reg <= evict ? fill_reg : fill_reg + FW'(1);
                    sum_reg  <= sum_upd;
                    sq_reg   <= sq_upd;
                end
            end
            wvcf_pkg::ST_MUL: begin
                nq_reg <= nq_full;
                ss_reg <= ss_full[PW-1:0];
                m_reg  <= m_full;
            end
            wvcf_pkg::ST_DIFF: begin
                num_reg <= diff_w[PW-1:wvcf_pkg::Q_SHIFT];
                rem_reg <= '0;
                cnt_reg <= CNTW'(QW);
            end
            wvcf_pkg::ST_DIV: begin
                rem_reg <= trial_ge ? MW'(trial - {1'b0, m_reg}) : MW'(trial);
                num_reg <= {num_reg[QW-2:0], trial_ge};
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            default: begin
            end
        endcase
    end

    // A short path (zero numerator or fewer than two samples) is flagged here.
    // (ST_DIFF loads the shifted numerator even when a short path skips ST_DIV,
    // so the flag makes the output use a variance of zero instead.)
    logic zero_var_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == wvcf_pkg::ST_IDLE) begin
            zero_var_reg <= 1'b1;
        end else if (state_reg == wvcf_pkg::ST_DIFF) begin
            zero_var_reg <= (fill_reg < FW'(2)) || (nq_reg <= ss_reg);
        end
    end

    // Output register: holds a finished result until it is transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Covariance when the variance itself is zero.
    function automatic logic [33:0] cov_w_zero(input wvcf_pkg::cfg_t c, input logic [33:0] inc);
        logic [33:0] r;
        r = c.compare_with_incoming ? inc : c.floor_level;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_channel <= chan_reg;
            if (ok_reg) begin
                m_data_reg.covariance_out <= zero_var_reg ? cov_w_zero(cfg, inc_reg) : cov_w;
                m_data_reg.sample_kept    <= keep_reg;
                m_data_reg.window_count   <= 8'(fill_reg);
            end else begin
                m_data_reg.covariance_out <= '0;
                m_data_reg.sample_kept    <= 1'b0;
                m_data_reg.window_count   <= '0;
            end
        end
    end

endmodule

// File: hdl/windowed_variance_covariance_floor.sv
// ----------------------------------------------------------------------------
// Windowed variance with covariance floor
// Per-channel sliding-window sample variance of odometry samples, raised
// to the incoming covariance or to a programmable floor.
// ----------------------------------------------------------------------------
// Usage:
// Input items (channel, Q12.12 sample, incoming covariance) arrive on the
// s_ valid/ready channel; each yields exactly one result on the m_ channel,
// in order. Configuration is written through cfg_wr_en/cfg_wr_index/
// cfg_wr_data while the block is idle; indexes beyond the list are ignored.
// Processing: an in-range item passes through the states RD_NEW, CMP, OLD,
// SQ, UPD, MUL and DIFF, then the bit-serial divider, one quotient bit per
// cycle, and DONE, from which the result enters the output register.
// A window of fewer than two samples or a zero numerator skips the divider;
// an out-of-range channel goes straight to DONE. Items are processed one at
// a time: the engine takes the next item only once the last result is loaded.
// A two-entry queue in front of the engine takes items while the engine
// works, and the output register holds a result while the receiver stalls;
// the engine waits in its final state until that register is free.
// After reset the window memory, all CHANNELS*WINDOW_DEPTH entries (1536 at
// the defaults), is cleared; s_ready stays low while it is cleared.
// ----------------------------------------------------------------------------
module windowed_variance_covariance_floor #(
    parameter int WINDOW_DEPTH = 128,
    parameter int CHANNELS     = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wvcf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wvcf_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_index,
    input  logic [33:0]         cfg_wr_data
);

    wvcf_pkg::cfg_t      cfg_reg;
    wvcf_pkg::fr_to_bk_t head;
    wvcf_pkg::bk_to_fr_t status;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_enable         <= 1'b0;
            cfg_reg.reject_threshold      <= '0;
            cfg_reg.window_limit          <= wvcf_pkg::WINDOW_LIMIT_RST;
            cfg_reg.compare_with_incoming <= 1'b1;
            cfg_reg.floor_level           <= wvcf_pkg::FLOOR_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                wvcf_pkg::CFG_FILTER_ENABLE: cfg_reg.filter_enable <= cfg_wr_data[0];
                wvcf_pkg::CFG_REJECT_THRESH: cfg_reg.reject_threshold <= cfg_wr_data[23:0];
                wvcf_pkg::CFG_WINDOW_LIMIT:  cfg_reg.window_limit <= cfg_wr_data[7:0];
                wvcf_pkg::CFG_COMPARE_IN:    cfg_reg.compare_with_incoming <= cfg_wr_data[0];
                wvcf_pkg::CFG_FLOOR_LEVEL:   cfg_reg.floor_level <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: accept, classify and queue.
    wvcf_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .head    (head),
        .status  (status)
    );

    // Engine: window update, variance and output register.
    wvcf_back #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .CHANNELS    (CHANNELS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .head    (head),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hdl/wvcf_checker.sv
// ----------------------------------------------------------------------------
// Windowed variance port checker
// Port-level assertions on the result channel and the reset behavior.
// ----------------------------------------------------------------------------
module wvcf_port_props #(
    parameter int CHANNELS = 12
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input wvcf_pkg::out_item_t m_data
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // A result for an unknown channel carries nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({1'b0, m_data.out_channel} >= 5'(CHANNELS)) |->
        (m_data.covariance_out == '0) && !m_data.sample_kept &&
        (m_data.window_count == '0))
        else $error("out-of-range channel produced a nonzero result");

    // No item is taken right after reset while the memory is cleared.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during memory clearing");

    // No result appears right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind windowed_variance_covariance_floor wvcf_port_props #(
    .CHANNELS(CHANNELS)
) u_wvcf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
